// ----- design/svn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svn_pkg
// Shared types and constants for the spoke vector normaliser.
// ----------------------------------------------------------------------------
package svn_pkg;

    localparam int CoordW   = 32;
    localparam int SqrtSteps = 32;
    localparam int QuoW     = 31;
    localparam int NormSteps = 5;
    localparam logic [QuoW-1:0] UnitQ30 = 31'h4000_0000;

    // Record travelling down the square-root cell row.
    typedef struct packed {
        logic [63:0]             rad;     // radicand bits still to consume
        logic [31:0]             root;
        logic [33:0]             rem;
        logic [31:0]             len;     // floor root of the unscaled sum
        logic                    len_up;  // round the length up
        logic [4:0]              shift;   // pairs of bits of normalisation
        logic [2:0][CoordW-1:0]  mag;
        logic [2:0]              neg;
        logic                    clip;
        logic                    zero;
    } t_sq;

    // Record travelling down the divider cell row, three lanes.
    typedef struct packed {
        logic [2:0][QuoW-1:0]    num;     // dividend bits still to consume
        logic [2:0][31:0]        rem;
        logic [2:0][QuoW-1:0]    quo;
        logic [31:0]             root;
        logic [31:0]             len;
        logic [2:0]              neg;
        logic                    clip;
        logic                    zero;
    } t_dv;

endpackage

// ----- design/svn_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svn_front
// Difference, saturation, squares, sum and normalisation to a radicand
// of at least 2^62.
// ----------------------------------------------------------------------------
module svn_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [2:0][31:0]           i_tip,
    input  logic [2:0][31:0]           i_tail,
    output logic                       o_valid,
    output svn_pkg::t_sq               o_sq
);
    import svn_pkg::*;

    typedef struct packed {
        logic [2:0][CoordW-1:0] mag;
        logic [2:0]             neg;
        logic                   clip;
        logic                   zero;
    } t_vec;

    typedef struct packed {
        logic [63:0] sum;
        logic [4:0]  shift;
        t_vec        v;
    } t_nrm;

    t_vec                r_a, n_a;
    logic [2:0][63:0]    r_sqr;
    t_vec                r_b;
    t_nrm                r_c;
    t_nrm                r_n [NormSteps];
    logic [NormSteps+2:0] r_vld;

    always_comb begin
        logic [32:0] d;
        logic [31:0] ds;
        n_a.clip = 1'b0;
        n_a.zero = (i_tip == i_tail);
        for (int k = 0; k < 3; k++) begin
            d = {i_tip[k][31], i_tip[k]} - {i_tail[k][31], i_tail[k]};
            if (d[32] != d[31]) begin
                ds = d[32] ? 32'h8000_0000 : 32'h7fff_ffff;
                n_a.clip = 1'b1;
            end else begin
                ds = d[31:0];
            end
            n_a.neg[k] = ds[31];
            n_a.mag[k] = ds[31] ? (32'd0 - ds) : ds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NormSteps+1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= n_a;
            for (int k = 0; k < 3; k++) begin
                r_sqr[k] <= 64'(r_a.mag[k]) * 64'(r_a.mag[k]);
            end
            r_b <= r_a;
            r_c.sum   <= r_sqr[0] + r_sqr[1] + r_sqr[2];
            r_c.shift <= '0;
            r_c.v     <= r_b;
        end
    end

    // Each step tests a halving field of leading zeros and shifts it out.
    for (genvar j = 0; j < NormSteps; j++) begin : g_nrm
        localparam int Amt = 32 >> j;
        t_nrm src;
        assign src = (j == 0) ? r_c : r_n[(j == 0) ? 0 : j-1];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[j].v <= src.v;
                if (src.sum[63 -: Amt] == '0) begin
                    r_n[j].sum   <= src.sum << Amt;
                    r_n[j].shift <= src.shift + 5'(Amt / 2);
                end else begin
                    r_n[j].sum   <= src.sum;
                    r_n[j].shift <= src.shift;
                end
            end
        end
    end

    assign o_valid = r_vld[NormSteps+2];

    always_comb begin
        o_sq        = '0;
        o_sq.rad    = r_n[NormSteps-1].sum;
        o_sq.shift  = r_n[NormSteps-1].shift;
        o_sq.mag    = r_n[NormSteps-1].v.mag;
        o_sq.neg    = r_n[NormSteps-1].v.neg;
        o_sq.clip   = r_n[NormSteps-1].v.clip;
        o_sq.zero   = r_n[NormSteps-1].v.zero;
    end

endmodule

// ----- design/svn_sqrt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svn_sqrt_cell
// One registered step of the digit-by-digit square root: one root bit.
// ----------------------------------------------------------------------------
module svn_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic [4:0]     i_step,
    input  logic           i_valid,
    input  svn_pkg::t_sq   i_sq,
    output logic           o_valid,
    output svn_pkg::t_sq   o_sq
);
    import svn_pkg::*;

    logic  r_valid;
    t_sq   r_sq, n_sq;

    always_comb begin
        logic [35:0] acc;
        logic [35:0] trial;
        logic        ge;
        n_sq     = i_sq;
        acc      = {i_sq.rem, i_sq.rad[63:62]};
        trial    = {2'b00, i_sq.root, 2'b01};
        ge       = (acc >= trial);
        n_sq.rem = ge ? 34'(acc - trial) : acc[33:0];
        n_sq.root = {i_sq.root[30:0], ge};
        n_sq.rad  = {i_sq.rad[61:0], 2'b00};
        // The first 32-s root bits are the root of the unscaled sum, and
        // the remainder at that point decides the rounding of the length.
        if (6'(i_step) + 6'(i_sq.shift) == 6'd31) begin
            n_sq.len    = {i_sq.root[30:0], ge};
            n_sq.len_up = (36'(n_sq.rem) > 36'({i_sq.root[30:0], ge}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= n_sq;
        end
    end

    assign o_valid = r_valid;
    assign o_sq    = r_sq;

endmodule

// ----- design/svn_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svn_div_cell
// One registered restoring-division step for all three lanes.
// ----------------------------------------------------------------------------
module svn_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  svn_pkg::t_dv   i_dv,
    output logic           o_valid,
    output svn_pkg::t_dv   o_dv
);
    import svn_pkg::*;

    logic  r_valid;
    t_dv   r_dv, n_dv;

    always_comb begin
        logic [32:0] t;
        logic        ge;
        n_dv = i_dv;
        for (int k = 0; k < 3; k++) begin
            t  = {i_dv.rem[k], i_dv.num[k][QuoW-1]};
            ge = (t >= {1'b0, i_dv.root});
            n_dv.rem[k] = ge ? 32'(t - {1'b0, i_dv.root}) : t[31:0];
            n_dv.quo[k] = {i_dv.quo[k][QuoW-2:0], ge};
            n_dv.num[k] = {i_dv.num[k][QuoW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv <= n_dv;
        end
    end

    assign o_valid = r_valid;
    assign o_dv    = r_dv;

endmodule

// ----- design/spoke_vector_normalize_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spoke_vector_normalize_top
// Length and unit direction of the difference of two Q16.16 points.
// ----------------------------------------------------------------------------
// One transaction is taken every cycle while the output is not stalled. Each
// result passes registers for difference, squares, sum and normalisation, a
// row of 32 square-root cells, one set-up register, a row of 31 divider cells
// and the output register. The whole pipeline advances whenever the output
// register is empty or being taken, so a stalled output holds everything.
module spoke_vector_normalize_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // tip_x, tip_y, tip_z, tail_x, tail_y, tail_z from bit 0 up
    input  logic [191:0]  i_s_axis_tdata,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // dir_x, dir_y, dir_z, spoke_length from bit 0 up
    output logic [127:0]  o_m_axis_tdata,
    // zero_length, clipped from bit 0 up
    output logic [1:0]    o_m_axis_tuser
);
    import svn_pkg::*;

    logic              en;
    logic [2:0][31:0]  tip, tail;
    logic              f_valid;
    t_sq               f_sq;
    logic              sq_valid [SqrtSteps+1];
    t_sq               sq_data  [SqrtSteps+1];
    logic              r_p_valid;
    t_dv               r_p, n_p;
    logic              dv_valid [QuoW+1];
    t_dv               dv_data  [QuoW+1];
    logic              r_o_valid;
    logic [127:0]      r_o_data, n_o_data;
    logic [1:0]        r_o_user, n_o_user;

    assign en = !r_o_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    assign tip  = i_s_axis_tdata[95:0];
    assign tail = i_s_axis_tdata[191:96];

    svn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_tip   (tip),
        .i_tail  (tail),
        .o_valid (f_valid),
        .o_sq    (f_sq)
    );

    assign sq_valid[0] = f_valid;
    assign sq_data[0]  = f_sq;

    for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
        svn_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_step  (5'(k)),
            .i_valid (sq_valid[k]),
            .i_sq    (sq_data[k]),
            .o_valid (sq_valid[k+1]),
            .o_sq    (sq_data[k+1])
        );
    end

    // Dividend per lane is (mag << s) * 2^30 plus half the root.
    always_comb begin
        t_sq         s;
        logic [31:0] num;
        logic [62:0] full;
        s = sq_data[SqrtSteps];
        n_p = '0;
        n_p.root = s.root;
        n_p.len  = s.len + 32'(s.len_up);
        n_p.neg  = s.neg;
        n_p.clip = s.clip;
        n_p.zero = s.zero;
        for (int k = 0; k < 3; k++) begin
            num  = s.mag[k] << s.shift;
            full = {1'b0, num, 30'd0} + 63'(s.root[31:1]);
            n_p.rem[k] = full[62:31];
            n_p.num[k] = full[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (en) begin
            r_p_valid <= sq_valid[SqrtSteps];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p <= n_p;
        end
    end

    assign dv_valid[0] = r_p_valid;
    assign dv_data[0]  = r_p;

    for (genvar k = 0; k < QuoW; k++) begin : g_div
        svn_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_valid[k]),
            .i_dv    (dv_data[k]),
            .o_valid (dv_valid[k+1]),
            .o_dv    (dv_data[k+1])
        );
    end

    always_comb begin
        t_dv             d;
        logic [QuoW-1:0] q;
        logic [31:0]     dir;
        d = dv_data[QuoW];
        n_o_data = '0;
        for (int k = 0; k < 3; k++) begin
            q   = (d.quo[k] > UnitQ30) ? UnitQ30 : d.quo[k];
            dir = d.neg[k] ? (32'd0 - 32'(q)) : 32'(q);
            n_o_data[k*32 +: 32] = d.zero ? 32'd0 : dir;
        end
        n_o_data[127:96] = d.zero ? 32'd0 : d.len;
        n_o_user = {d.clip, d.zero};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= dv_valid[QuoW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_data <= n_o_data;
            r_o_user <= n_o_user;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tuser  = r_o_user;

    // A zero-length spoke has no direction, no length and no saturation.
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            o_m_axis_tdata == '0 && !o_m_axis_tuser[1])
        else $error("zero-length result carries non-zero fields");

    // Direction components never exceed one in magnitude.
    a_dir_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ($signed(o_m_axis_tdata[31:0])  <= 32'sh4000_0000) &&
            ($signed(o_m_axis_tdata[31:0])  >= -32'sh4000_0000) &&
            ($signed(o_m_axis_tdata[63:32]) <= 32'sh4000_0000) &&
            ($signed(o_m_axis_tdata[63:32]) >= -32'sh4000_0000) &&
            ($signed(o_m_axis_tdata[95:64]) <= 32'sh4000_0000) &&
            ($signed(o_m_axis_tdata[95:64]) >= -32'sh4000_0000))
        else $error("direction component out of range");

    // A non-degenerate spoke always has a non-zero length.
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata[127:96] != '0)
        else $error("non-zero spoke reported with zero length");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks spoke_vector_normalize_top: difference, length and unit direction.
// Spokes are streamed in with random gaps, results are taken with random
// stalls, and every result is compared with a prediction made per spoke.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct packed {
        logic [31:0] dir_x;
        logic [31:0] dir_y;
        logic [31:0] dir_z;
        logic [31:0] spoke_length;
        logic        zero_length;
        logic        clipped;
    } t_spoke_res;

    class spoke_scoreboard;
        t_spoke_res pending[$];
        int unsigned n_checked;
        int unsigned n_errors;

        function logic [63:0] root_floor(logic [63:0] v);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function void note_spoke(logic [191:0] data);
            t_spoke_res res;
            logic signed [33:0] diff;
            logic signed [31:0] comp [3];
            logic [63:0] mag [3];
            logic [63:0] sum;
            logic [63:0] r;
            logic [63:0] scaled;
            logic [127:0] q;
            int s;
            res = '0;
            sum = 0;
            for (int k = 0; k < 3; k++) begin
                diff = $signed(data[32*k +: 32]) - $signed(data[32*(k+3) +: 32]);
                if (diff > 34'sd2147483647) begin
                    comp[k] = 32'sh7FFF_FFFF;
                    res.clipped = 1'b1;
                end else if (diff < -34'sd2147483648) begin
                    comp[k] = 32'sh8000_0000;
                    res.clipped = 1'b1;
                end else begin
                    comp[k] = diff[31:0];
                end
                mag[k] = comp[k] < 0 ? 64'(-64'(comp[k])) : 64'(comp[k]);
                sum = sum + mag[k] * mag[k];
            end
            if (sum == 0) begin
                res.zero_length = 1'b1;
            end else begin
                r = root_floor(sum);
                if (sum - r * r > r) r = r + 1;
                res.spoke_length = r[31:0];
                scaled = sum;
                s = 0;
                while (scaled < 64'h4000_0000_0000_0000) begin
                    scaled = scaled << 2;
                    s++;
                end
                r = root_floor(scaled);
                for (int k = 0; k < 3; k++) begin
                    q = (((128'(mag[k]) << s) << 30) + (r >> 1)) / r;
                    if (q > 128'h4000_0000) q = 128'h4000_0000;
                    if (comp[k] < 0) q = -q;
                    if (k == 0) res.dir_x = q[31:0];
                    else if (k == 1) res.dir_y = q[31:0];
                    else res.dir_z = q[31:0];
                end
            end
            pending = {pending, res};
        endfunction

        function void check_result(logic [127:0] data, logic [1:0] user);
            t_spoke_res want;
            if (pending.size() == 0) begin
                $error("result with no spoke outstanding");
                n_errors++;
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (data[31:0] !== want.dir_x) begin
                $error("dir_x expected %h got %h", want.dir_x, data[31:0]); n_errors++;
            end
            if (data[63:32] !== want.dir_y) begin
                $error("dir_y expected %h got %h", want.dir_y, data[63:32]); n_errors++;
            end
            if (data[95:64] !== want.dir_z) begin
                $error("dir_z expected %h got %h", want.dir_z, data[95:64]); n_errors++;
            end
            if (data[127:96] !== want.spoke_length) begin
                $error("spoke_length expected %h got %h", want.spoke_length,
                       data[127:96]);
                n_errors++;
            end
            if (user[0] !== want.zero_length) begin
                $error("zero_length expected %b got %b", want.zero_length, user[0]);
                n_errors++;
            end
            if (user[1] !== want.clipped) begin
                $error("clipped expected %b got %b", want.clipped, user[1]); n_errors++;
            end
        endfunction
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_s_axis_tvalid = 1'b0;
    logic          o_s_axis_tready;
    logic [191:0]  i_s_axis_tdata = '0;
    logic          o_m_axis_tvalid;
    logic          i_m_axis_tready = 1'b0;
    logic [127:0]  o_m_axis_tdata;
    logic [1:0]    o_m_axis_tuser;

    spoke_scoreboard board = new;
    bit quiet_phase = 0;
    bit stim_done = 0;
    int unsigned n_sent = 0;
    int unsigned n_clipped = 0;
    int unsigned n_zero = 0;

    always #4 i_clk = ~i_clk;

    spoke_vector_normalize_top i_dut (.*);

    // Result side: random stalls, then checking of each transaction.
    initial begin
        int stall;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 4);
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (o_m_axis_tuser[0]) n_zero++;
                if (o_m_axis_tuser[1]) n_clipped++;
                board.check_result(o_m_axis_tdata, o_m_axis_tuser);
            end
        end
    end

    function logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(int'($urandom_range(0, 200)) - 100);
            3: return 32'(int'($urandom_range(0, 2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_spoke(logic [191:0] data);
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        board.note_spoke(data);
        n_sent++;
    endtask

    task automatic send_points(logic [31:0] tx, ty, tz, ax, ay, az);
        send_spoke({az, ay, ax, tz, ty, tx});
    endtask

    initial begin
        logic [191:0] d;
        logic [95:0] tip;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero length, axes, extremes and saturation both ways.
        send_points(0, 0, 0, 0, 0, 0);
        send_points(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);
        send_points(32'h0001_0000, 0, 0, 0, 0, 0);
        send_points(0, 32'hFFFF_0000, 0, 0, 0, 0);
        send_points(0, 0, 1, 0, 0, 0);
        send_points(0, 0, 0, 0, 0, 1);
        send_points(1, 1, 1, 0, 0, 0);
        send_points(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0);
        send_points(0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0);
        send_points(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_points(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_points(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
        send_points(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
        send_points(0, 0, 32'h8000_0000, 0, 0, 0);
        send_points(3, 4, 0, 0, 0, 0);
        send_points(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
        send_points(0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Hold off until the pipeline has drained completely.
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);

        for (int n = 0; n < 1400; n++) begin
            if (n == 1150) quiet_phase = 1;
            for (int k = 0; k < 6; k++) d[32*k +: 32] = pick_coord();
            tip = d[95:0];
            case ($urandom_range(0, 9))
                0: d[191:96] = tip;                            // zero length
                1: d[191:96] = tip ^ (96'd1 << $urandom_range(0, 95));
                default: ;
            endcase
            send_spoke(d);
        end
        i_s_axis_tvalid <= 1'b0;
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Sent %0d spokes, checked %0d results (%0d zero length, %0d clipped).",
                 n_sent, board.n_checked, n_zero, n_clipped);
        if (board.n_errors == 0 && board.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- spoke_vector_normalize_top.f -----
design/svn_pkg.sv
design/svn_front.sv
design/svn_sqrt_cell.sv
design/svn_div_cell.sv
design/spoke_vector_normalize_top.sv
sim/testbench.sv
